@@ rtl/core/brl_pkg.sv @@
// brl_pkg: shared types for the line raster unit
// holds the item kind encoding used by the back end and the port checker
// no dependencies
package brl_pkg;

    // item kind carried on the kind port and through the command queue
    typedef enum logic {
        KIND_START   = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

endpackage

@@ rtl/core/bresenham_line_raster_unit.sv @@
// bresenham_line_raster_unit: all-octant integer line rasterizer, top level
// depends on brl_pkg, brl_front, brl_fifo, brl_back
//
//   channel  | handshake        | fields
//   ---------+------------------+-------------------------------------------
//   item in  | push / full      | kind, start_x, start_y, end_x, end_y
//   pixel out| empty / pop      | pixel_x, pixel_y, last_pixel
//
// one item is taken per cycle and one pixel leaves per cycle while no queue
// stalls, set by the single add-compare error update in the back end stepper
// a pixel passes the front register, the command queue and the result queue
// reset clears all queues and the active line; nothing to wait for after reset
// a stalled result queue holds the stepper, which then backs up the command
// queue and the input stage; an advance with no active line gives no pixel
module bresenham_line_raster_unit
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int CMD_DEPTH  = 2,
    parameter int RES_DEPTH  = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  kind,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);

    localparam int CMD_W = 6 * COORD_BITS + 4;
    localparam int RES_W = 2 * COORD_BITS + 1;

    logic                  in_ready;
    logic                  f_valid, f_ready, cq_full, cq_empty, cq_pop;
    kind_t                 f_kind, b_kind;
    logic [COORD_BITS-1:0] f_x1, f_y1, f_x2, f_y2, f_adx, f_ady;
    logic                  f_sxn, f_syn, f_xmaj;
    logic [COORD_BITS-1:0] b_x1, b_y1, b_x2, b_y2, b_adx, b_ady;
    logic                  b_sxn, b_syn, b_xmaj, b_kind_bit;
    logic [CMD_W-1:0]      cq_wdata, cq_rdata;
    logic                  r_push, r_full, r_last;
    logic [COORD_BITS-1:0] r_x, r_y;

    assign full    = !in_ready;
    assign f_ready = !cq_full;

    // front: input stage and line setup
    brl_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (in_ready),
        .kind      (kind_t'(kind)),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_kind  (f_kind),
        .cmd_x1    (f_x1),
        .cmd_y1    (f_y1),
        .cmd_x2    (f_x2),
        .cmd_y2    (f_y2),
        .cmd_adx   (f_adx),
        .cmd_ady   (f_ady),
        .cmd_sxn   (f_sxn),
        .cmd_syn   (f_syn),
        .cmd_xmaj  (f_xmaj)
    );

    // command queue between front and back
    assign cq_wdata = {f_kind, f_x1, f_y1, f_x2, f_y2, f_adx, f_ady, f_sxn, f_syn, f_xmaj};
    assign {b_kind_bit, b_x1, b_y1, b_x2, b_y2, b_adx, b_ady, b_sxn, b_syn, b_xmaj} = cq_rdata;
    assign b_kind = kind_t'(b_kind_bit);

    brl_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .wdata (cq_wdata),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    // back: stepper
    brl_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cq_empty),
        .cmd_pop   (cq_pop),
        .cmd_kind  (b_kind),
        .cmd_x1    (b_x1),
        .cmd_y1    (b_y1),
        .cmd_x2    (b_x2),
        .cmd_y2    (b_y2),
        .cmd_adx   (b_adx),
        .cmd_ady   (b_ady),
        .cmd_sxn   (b_sxn),
        .cmd_syn   (b_syn),
        .cmd_xmaj  (b_xmaj),
        .res_push  (r_push),
        .res_full  (r_full),
        .res_x     (r_x),
        .res_y     (r_y),
        .res_last  (r_last)
    );

    // result queue toward the pixel consumer
    brl_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata ({r_x, r_y, r_last}),
        .full  (r_full),
        .pop   (pop),
        .rdata ({pixel_x, pixel_y, last_pixel}),
        .empty (empty)
    );

endmodule

@@ rtl/core/brl_fifo.sv @@
// brl_fifo: small register based queue with count
// used between front and back and as the result queue
// no package dependencies
module brl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, written on transfer in
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/brl_front.sv @@
// brl_front: accepts items and classifies line setups
// computes absolute deltas, step directions and major axis into a register stage
// depends on brl_pkg
module brl_front
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kind_t                 kind,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output kind_t                 cmd_kind,
    output logic [COORD_BITS-1:0] cmd_x1,
    output logic [COORD_BITS-1:0] cmd_y1,
    output logic [COORD_BITS-1:0] cmd_x2,
    output logic [COORD_BITS-1:0] cmd_y2,
    output logic [COORD_BITS-1:0] cmd_adx,
    output logic [COORD_BITS-1:0] cmd_ady,
    output logic                  cmd_sxn,
    output logic                  cmd_syn,
    output logic                  cmd_xmaj
);

    logic                  valid_reg, valid_next;
    kind_t                 kind_reg;
    logic [COORD_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg, adx_reg, ady_reg;
    logic                  sxn_reg, syn_reg, xmaj_reg;
    logic                  x_up, y_up, take;
    logic [COORD_BITS-1:0] adx, ady;

    assign in_ready = !valid_reg || cmd_ready;
    assign take     = in_valid && in_ready;

    // classify: deltas, directions, major axis
    always_comb
    begin
        x_up = end_x > start_x;
        y_up = end_y > start_y;
        adx  = x_up ? end_x - start_x : start_x - end_x;
        ady  = y_up ? end_y - start_y : start_y - end_y;
    end

    assign valid_next = take || (valid_reg && !cmd_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload stage, loaded on transfer in
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= kind;
            x1_reg   <= start_x;
            y1_reg   <= start_y;
            x2_reg   <= end_x;
            y2_reg   <= end_y;
            adx_reg  <= adx;
            ady_reg  <= ady;
            sxn_reg  <= !x_up;
            syn_reg  <= !y_up;
            xmaj_reg <= adx > ady;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd_kind  = kind_reg;
    assign cmd_x1    = x1_reg;
    assign cmd_y1    = y1_reg;
    assign cmd_x2    = x2_reg;
    assign cmd_y2    = y2_reg;
    assign cmd_adx   = adx_reg;
    assign cmd_ady   = ady_reg;
    assign cmd_sxn   = sxn_reg;
    assign cmd_syn   = syn_reg;
    assign cmd_xmaj  = xmaj_reg;

endmodule

@@ rtl/core/brl_back.sv @@
// brl_back: line stepper holding the active line state
// one pixel and at most one error update per start or active-line advance
// results go to the result queue; depends on brl_pkg
module brl_back
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  kind_t                 cmd_kind,
    input  logic [COORD_BITS-1:0] cmd_x1,
    input  logic [COORD_BITS-1:0] cmd_y1,
    input  logic [COORD_BITS-1:0] cmd_x2,
    input  logic [COORD_BITS-1:0] cmd_y2,
    input  logic [COORD_BITS-1:0] cmd_adx,
    input  logic [COORD_BITS-1:0] cmd_ady,
    input  logic                  cmd_sxn,
    input  logic                  cmd_syn,
    input  logic                  cmd_xmaj,
    output logic                  res_push,
    input  logic                  res_full,
    output logic [COORD_BITS-1:0] res_x,
    output logic [COORD_BITS-1:0] res_y,
    output logic                  res_last
);

    localparam int EW = COORD_BITS + 2;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] adx_reg, adx_next, ady_reg, ady_next;
    logic [COORD_BITS-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [EW-1:0]  err_reg, err_next;
    logic                  sxn_reg, sxn_next, syn_reg, syn_next;
    logic                  xmaj_reg, xmaj_next, active_reg, active_next;

    // working values: freshly loaded line or the one in progress
    logic [COORD_BITS-1:0] s_x, s_y, s_adx, s_ady, s_tx, s_ty, s_major, s_minor;
    logic signed [EW-1:0]  s_err, err_add, minor2, major2;
    logic                  s_sxn, s_syn, s_xmaj, is_start, go, last;
    logic [COORD_BITS-1:0] x_step, y_step;

    assign is_start = (cmd_kind == KIND_START);
    assign go       = cmd_valid && !res_full;
    assign cmd_pop  = go;
    assign res_push = go && (is_start || active_reg);

    always_comb
    begin
        if (is_start)
        begin
            s_x    = cmd_x1;
            s_y    = cmd_y1;
            s_adx  = cmd_adx;
            s_ady  = cmd_ady;
            s_tx   = cmd_x2;
            s_ty   = cmd_y2;
            s_sxn  = cmd_sxn;
            s_syn  = cmd_syn;
            s_xmaj = cmd_xmaj;
        end
        else
        begin
            s_x    = cur_x_reg;
            s_y    = cur_y_reg;
            s_adx  = adx_reg;
            s_ady  = ady_reg;
            s_tx   = tx_reg;
            s_ty   = ty_reg;
            s_sxn  = sxn_reg;
            s_syn  = syn_reg;
            s_xmaj = xmaj_reg;
        end
        s_major = s_xmaj ? s_adx : s_ady;
        s_minor = s_xmaj ? s_ady : s_adx;
        major2  = signed'({1'b0, s_major, 1'b0});
        minor2  = signed'({1'b0, s_minor, 1'b0});
        // a new line starts at minus the major delta
        s_err   = is_start ? -signed'({2'b00, s_major}) : err_reg;
        err_add = s_err + minor2;
        last    = s_xmaj ? (s_x == s_tx) : (s_y == s_ty);
        x_step  = s_sxn ? s_x - 1'b1 : s_x + 1'b1;
        y_step  = s_syn ? s_y - 1'b1 : s_y + 1'b1;
    end

    // next line state
    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        err_next    = err_reg;
        sxn_next    = sxn_reg;
        syn_next    = syn_reg;
        xmaj_next   = xmaj_reg;
        active_next = active_reg;
        if (res_push)
        begin
            adx_next  = s_adx;
            ady_next  = s_ady;
            tx_next   = s_tx;
            ty_next   = s_ty;
            sxn_next  = s_sxn;
            syn_next  = s_syn;
            xmaj_next = s_xmaj;
            cur_x_next = s_x;
            cur_y_next = s_y;
            err_next   = s_err;
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next = 1'b1;
                err_next    = (err_add > 0) ? err_add - major2 : err_add;
                if (s_xmaj)
                begin
                    cur_x_next = x_step;
                    if (err_add > 0 && s_y != s_ty)
                    begin
                        cur_y_next = y_step;
                    end
                end
                else
                begin
                    cur_y_next = y_step;
                    if (err_add > 0 && s_x != s_tx)
                    begin
                        cur_x_next = x_step;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            adx_reg    <= '0;
            ady_reg    <= '0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            err_reg    <= '0;
            sxn_reg    <= 1'b0;
            syn_reg    <= 1'b0;
            xmaj_reg   <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            adx_reg    <= adx_next;
            ady_reg    <= ady_next;
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            err_reg    <= err_next;
            sxn_reg    <= sxn_next;
            syn_reg    <= syn_next;
            xmaj_reg   <= xmaj_next;
            active_reg <= active_next;
        end
    end

    assign res_x    = s_x;
    assign res_y    = s_y;
    assign res_last = last;

endmodule

@@ rtl/core/brl_checker.sv @@
// brl_checker: port level assertions for the line raster unit
// bound to bresenham_line_raster_unit; depends on brl_pkg
module brl_checker
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  kind,
    input logic                  empty,
    input logic                  pop,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic                  last_pixel
);

    logic seen_start_reg, seen_start_next;

    // remembers whether any start transfer has happened since reset
    assign seen_start_next = seen_start_reg ||
                             (push && !full && (kind_t'(kind) == KIND_START));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_start_reg <= 1'b0;
        end
        else
        begin
            seen_start_reg <= seen_start_next;
        end
    end

    // queues come out of reset empty and open
    a_reset_state: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not cleared in reset");

    // no pixel before some line has been started
    a_no_pixel_without_line: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> seen_start_reg)
        else $error("pixel produced with no line ever started");

    // a waiting pixel stays
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting pixel dropped");

    // a waiting pixel does not change
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel)))
        else $error("waiting pixel changed");

endmodule

bind bresenham_line_raster_unit brl_checker #(.COORD_BITS(COORD_BITS)) u_brl_checker (.*);

@@ tb/testbench.sv @@
// testbench for bresenham_line_raster_unit: directed lines, then random lines under four idle mixes
// depends on brl_pkg and the rtl top level; the line predictor and scoreboard live in this file
`timescale 1ns / 100ps

module testbench;
    import brl_pkg::*;

    localparam int CB             = 12;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;
    localparam int PHASE_PIXELS   = 180;
    localparam int MAX_REPORTS    = 20;
    localparam int LONG_ADVANCES  = 40;

    typedef logic [CB-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    // line predictor plus queue of pixels still owed by the block
    class line_scoreboard;
        coord_t            cur_x, cur_y, tgt_x, tgt_y, adx, ady;
        logic signed [CB+1:0] err;
        bit                sxn, syn, xmaj, active;
        pixel_t            owed_q[$];
        int                errors, n_expected, n_checked, n_lines, n_ignored;

        function new();
            cur_x = '0; cur_y = '0; tgt_x = '0; tgt_y = '0; adx = '0; ady = '0;
            err = '0; sxn = 0; syn = 0; xmaj = 0; active = 0;
            errors = 0; n_expected = 0; n_checked = 0; n_lines = 0; n_ignored = 0;
        endfunction

        // queue the current pixel, then take one error step unless it was the last
        function void emit_pixel();
            pixel_t p;
            logic   last;
            last   = xmaj ? (cur_x == tgt_x) : (cur_y == tgt_y);
            p.x    = cur_x;
            p.y    = cur_y;
            p.last = last;
            owed_q.push_back(p);
            n_expected++;
            if (last)
            begin
                active = 0;
                return;
            end
            if (xmaj)
            begin
                err = err + $signed({1'b0, ady, 1'b0});
                if (err > 0)
                begin
                    if (cur_y != tgt_y)
                        cur_y = syn ? cur_y - 1'b1 : cur_y + 1'b1;
                    err = err - $signed({1'b0, adx, 1'b0});
                end
                cur_x = sxn ? cur_x - 1'b1 : cur_x + 1'b1;
            end
            else
            begin
                err = err + $signed({1'b0, adx, 1'b0});
                if (err > 0)
                begin
                    if (cur_x != tgt_x)
                        cur_x = sxn ? cur_x - 1'b1 : cur_x + 1'b1;
                    err = err - $signed({1'b0, ady, 1'b0});
                end
                cur_y = syn ? cur_y - 1'b1 : cur_y + 1'b1;
            end
        endfunction

        // accepted input transfer
        function void note_item(kind_t k, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            if (k == KIND_START)
            begin
                sxn   = !(ex > sx);
                syn   = !(ey > sy);
                adx   = (ex > sx) ? ex - sx : sx - ex;
                ady   = (ey > sy) ? ey - sy : sy - ey;
                xmaj  = adx > ady;
                err   = xmaj ? -$signed({2'b00, adx}) : -$signed({2'b00, ady});
                cur_x = sx;
                cur_y = sy;
                tgt_x = ex;
                tgt_y = ey;
                active = 1;
                n_lines++;
                emit_pixel();
            end
            else if (active)
                emit_pixel();
            else
                n_ignored++;
        endfunction

        function void report(string what, int exp_v, int act_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        endfunction

        // accepted output transfer
        function void check_pixel(coord_t px, coord_t py, logic lp);
            pixel_t e;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d last=%0b",
                             $time, px, py, lp);
                return;
            end
            e = owed_q.pop_front();
            n_checked++;
            if (px !== e.x)
                report("pixel_x", int'(e.x), int'(px));
            if (py !== e.y)
                report("pixel_y", int'(e.y), int'(py));
            if (lp !== e.last)
                report("last_pixel", int'(e.last), int'(lp));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   push;
    logic   full;
    logic   kind;
    coord_t start_x, start_y, end_x, end_y;
    logic   empty;
    logic   pop;
    coord_t pixel_x, pixel_y;
    logic   last_pixel;

    line_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  quiet_cycles;
    int  n_sent;

    bresenham_line_raster_unit #(.COORD_BITS(CB)) dut (.*);

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // monitor both transfers at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_item(kind_t'(kind), start_x, start_y, end_x, end_y);
            if (pop && !empty)
                sb.check_pixel(pixel_x, pixel_y, last_pixel);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one input transfer, entered and left at a falling edge
    task automatic send_item(kind_t k, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        kind    <= k;
        start_x <= sx;
        start_y <= sy;
        end_x   <= ex;
        end_y   <= ey;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    // advance with random don't-care coordinates
    task automatic send_advance();
        send_item(KIND_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic send_line(int sx, int sy, int ex, int ey, int n_adv);
        send_item(KIND_START, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
        repeat (n_adv) send_advance();
    endtask

    // sender pause until every owed pixel is back
    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // mostly short complete lines, some cut short, some full-range, some stray advances
    task automatic random_line();
        int sx, sy, ex, ey, dx, dy, major, n_adv;
        sx = $urandom_range(4095);
        sy = $urandom_range(4095);
        if ($urandom_range(15) == 0)
        begin
            ex = $urandom_range(4095);
            ey = $urandom_range(4095);
        end
        else
        begin
            dx = $urandom_range(12);
            dy = $urandom_range(12);
            ex = $urandom_range(1) ? sx + dx : sx - dx;
            ey = $urandom_range(1) ? sy + dy : sy - dy;
            if (ex < 0) ex = 0;
            if (ex > 4095) ex = 4095;
            if (ey < 0) ey = 0;
            if (ey > 4095) ey = 4095;
        end
        dx = (ex > sx) ? ex - sx : sx - ex;
        dy = (ey > sy) ? ey - sy : sy - ey;
        major = (dx > dy) ? dx : dy;
        if (major > 40)
            n_adv = $urandom_range(20);
        else if ($urandom_range(99) < 80)
            n_adv = major;
        else
            n_adv = $urandom_range(major);
        send_line(sx, sy, ex, ey, n_adv);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(2, 1)) send_advance();
    endtask

    task automatic random_phase(int idle_pct, int stall_pct);
        int goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = sb.n_expected + PHASE_PIXELS;
        while (sb.n_expected < goal)
            random_line();
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        push    = 1'b0;
        kind    = KIND_START;
        start_x = '0;
        start_y = '0;
        end_x   = '0;
        end_y   = '0;
        rst_n   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req     = 0;
        quiet_cycles = 0;
        n_sent       = 0;
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: stray advance, equal endpoints, advance after the end
        send_advance();
        send_line(0, 0, 0, 0, 0);
        send_advance();
        send_line(4095, 4095, 4095, 4095, 0);
        // flat line, minor axis never moves, cut by a new start
        send_line(0, 0, 4095, 0, 2);
        // equal deltas pick y as major; dropped by the next start
        send_line(4095, 4095, 0, 0, 2);
        // vertical line run to its end, then a stray advance
        send_line(5, 0, 5, 3, 3);
        send_advance();
        // steep line, and a shallow one stepping down in x
        send_line(0, 0, 2, 5, 5);
        send_line(7, 2, 3, 4, 4);
        wait_drained();

        // no idling, with one long receiver hold-off so the block fills up
        hold_req = 1;
        random_phase(0, 0);
        random_phase(45, 0);
        random_phase(0, 45);
        // two lines with the widest deltas, cut short, for large error swings
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        send_line(0, 4095, 4095, 1, LONG_ADVANCES);
        send_line(4095, 0, 1, 4095, LONG_ADVANCES);
        random_phase(32, 32);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d pixels never arrived", $time, sb.pending());
        end
        $display("covered %0d items, %0d pixels on %0d lines, %0d ignored advances",
                 n_sent, sb.n_checked, sb.n_lines, sb.n_ignored);
        $display("idle mixes: none, sender, receiver, both; plus a full-queue hold-off");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
